FILE: rtl/core/bellman_ford_shortest_paths_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shortest path block
// Clocked, reset-qualified implication checks used by the top level.
// ----------------------------------------------------------------------------
`ifndef BELLMAN_FORD_SHORTEST_PATHS_TOP_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bfsp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int WEIGHT_BITS  = 16;

    // Port widths fixed by the interface.
    localparam int ACTION_BITS    = 2;
    localparam int PORT_VTX_BITS  = 6;
    localparam int PORT_WT_BITS   = 16;
    localparam int DIST_BITS      = 32;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 7;

    localparam int VERTEX_BITS    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VCOUNT_BITS    = $clog2(MAX_VERTICES + 1);
    localparam int EDGE_ADDR_BITS = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EDGE_CNT_BITS  = $clog2(MAX_EDGES + 1);
    localparam int EDGE_BITS      = 2 * VERTEX_BITS + WEIGHT_BITS;
    localparam int DENTRY_BITS    = DIST_BITS + 1;

    localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_RUN    = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTEX_COUNT  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_VERTEX = 1'd1;

    typedef struct packed {
        logic clear_edges;
        logic append_edge;
        logic vert_clr;
        logic vert_inc;
        logic init_wr;
        logic edge_clr;
        logic edge_inc;
        logic pass_clr;
        logic pass_inc;
        logic edge_rd;
        logic dist_rd;
        logic relax_wr;
        logic out_rd;
        logic emit;
        logic emit_neg;
    } bfsp_cmd_t;

    typedef struct packed {
        logic vert_last;
        logic edge_last;
        logic edge_empty;
        logic detect_pass;
        logic improve;
    } bfsp_status_t;

endpackage

FILE: rtl/core/bellman_ford_shortest_paths_top.sv
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths_top
// Single-source shortest paths over a loaded edge list with negative cycle check.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Action clear empties
// the edge list and append stores one edge; for both, busy stays low.
// Appends beyond the store capacity are dropped.
// Action run raises busy. The block first initialises n distance entries,
// then relaxes every stored edge in load order for n-1 passes plus one
// check pass. For each edge: edge store read, distance store read of tail
// and head, then compare and write back. Results then follow, one per
// vertex, each read from the distance store and then shown, the last one
// marked by last; a negative cycle gives one flagged result instead.
// Every result is shown for exactly one cycle with result_valid high; the
// receiver cannot stall it. Configuration writes (cfg_valid/cfg_ready) set
// the vertex count and source vertex and should be made while busy is low.
// Reset empties the edge list, sets the vertex count to one and the source
// to vertex zero; the distance store holds nothing until a run starts.
// ----------------------------------------------------------------------------
`include "bellman_ford_shortest_paths_top_assert.svh"

module bellman_ford_shortest_paths_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [bfsp_pkg::ACTION_BITS-1:0]      action,
    input  logic [bfsp_pkg::PORT_VTX_BITS-1:0]    from_vertex,
    input  logic [bfsp_pkg::PORT_VTX_BITS-1:0]    to_vertex,
    input  logic signed [bfsp_pkg::PORT_WT_BITS-1:0] weight,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bfsp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bfsp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output logic                                  result_valid,
    output logic [bfsp_pkg::PORT_VTX_BITS-1:0]    vertex,
    output logic signed [bfsp_pkg::DIST_BITS-1:0] distance,
    output logic                                  reachable,
    output logic                                  negative_cycle,
    output logic                                  last
);

    import bfsp_pkg::*;

    bfsp_cmd_t    cmd;
    bfsp_status_t status;

    assign cfg_ready = 1'b1;

    bfsp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    bfsp_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .from_vertex    (from_vertex),
        .to_vertex      (to_vertex),
        .weight         (weight),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .vertex         (vertex),
        .distance       (distance),
        .reachable      (reachable),
        .negative_cycle (negative_cycle),
        .last           (last)
    );

    // A result can only come out of a run that was still in progress.
    `BFSP_ASSERT_SAME(a_result_in_run, result_valid, $past(busy), "result without a run")
    // The negative cycle result is always the only and final result.
    `BFSP_ASSERT_SAME(a_neg_is_last, result_valid && negative_cycle, last && !reachable,
        "negative cycle result not final")
    // After the final result the run is over, so no result follows at once.
    `BFSP_ASSERT_NEXT(a_last_ends_run, result_valid && last, !result_valid,
        "result after final result")
    // An unreachable vertex reports a zero distance.
    `BFSP_ASSERT_SAME(a_unreach_zero, result_valid && !reachable, distance == '0,
        "unreachable vertex with non-zero distance")

endmodule

FILE: rtl/core/bfsp_ram.sv
// ----------------------------------------------------------------------------
// bfsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                           clk,
    input  logic                                           wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]                               wr_data,
    input  logic                                           rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
    output logic [WIDTH-1:0]                               rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/bfsp_ctrl.sv
// ----------------------------------------------------------------------------
// bfsp_ctrl
// Sequencer for edge loading, distance initialisation, relaxation passes,
// the negative cycle check and result output.
// ----------------------------------------------------------------------------
module bfsp_ctrl (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [bfsp_pkg::ACTION_BITS-1:0]      action,
    output logic                                  busy,
    output bfsp_pkg::bfsp_cmd_t                   cmd,
    input  bfsp_pkg::bfsp_status_t                status
);

    import bfsp_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INIT     = 3'd1;
    localparam logic [2:0] S_EDGE_RD  = 3'd2;
    localparam logic [2:0] S_DIST_RD  = 3'd3;
    localparam logic [2:0] S_RELAX    = 3'd4;
    localparam logic [2:0] S_OUT_RD   = 3'd5;
    localparam logic [2:0] S_OUT_EMIT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (action)
                        ACT_CLEAR:  cmd.clear_edges = 1'b1;
                        ACT_APPEND: cmd.append_edge = 1'b1;
                        ACT_RUN:
                        begin
                            cmd.vert_clr = 1'b1;
                            state_next   = S_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (status.vert_last)
                begin
                    cmd.vert_clr = 1'b1;
                    cmd.edge_clr = 1'b1;
                    cmd.pass_clr = 1'b1;
                    state_next   = status.edge_empty ? S_OUT_RD : S_EDGE_RD;
                end
                else
                begin
                    cmd.vert_inc = 1'b1;
                end
            end
            S_EDGE_RD:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = S_DIST_RD;
            end
            S_DIST_RD:
            begin
                cmd.dist_rd = 1'b1;
                state_next  = S_RELAX;
            end
            S_RELAX:
            begin
                if (status.detect_pass && status.improve)
                begin
                    cmd.emit_neg = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.relax_wr = !status.detect_pass;
                    if (status.edge_last)
                    begin
                        cmd.edge_clr = 1'b1;
                        if (status.detect_pass)
                        begin
                            state_next = S_OUT_RD;
                        end
                        else
                        begin
                            cmd.pass_inc = 1'b1;
                            state_next   = S_EDGE_RD;
                        end
                    end
                    else
                    begin
                        cmd.edge_inc = 1'b1;
                        state_next   = S_EDGE_RD;
                    end
                end
            end
            S_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = S_OUT_EMIT;
            end
            S_OUT_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.vert_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.vert_inc = 1'b1;
                    state_next   = S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: rtl/core/bfsp_datapath.sv
// ----------------------------------------------------------------------------
// bfsp_datapath
// Edge store, distance store, counters, relaxation arithmetic and the
// result registers.
// ----------------------------------------------------------------------------
module bfsp_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bfsp_pkg::bfsp_cmd_t                   cmd,
    output bfsp_pkg::bfsp_status_t                status,
    input  logic [bfsp_pkg::PORT_VTX_BITS-1:0]    from_vertex,
    input  logic [bfsp_pkg::PORT_VTX_BITS-1:0]    to_vertex,
    input  logic signed [bfsp_pkg::PORT_WT_BITS-1:0] weight,
    input  logic                                  cfg_wr,
    input  logic [bfsp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bfsp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output logic                                  result_valid,
    output logic [bfsp_pkg::PORT_VTX_BITS-1:0]    vertex,
    output logic signed [bfsp_pkg::DIST_BITS-1:0] distance,
    output logic                                  reachable,
    output logic                                  negative_cycle,
    output logic                                  last
);

    import bfsp_pkg::*;

    logic [VCOUNT_BITS-1:0]    vertex_count_reg;
    logic [VERTEX_BITS-1:0]    source_reg;
    logic [EDGE_CNT_BITS-1:0]  edge_total_reg;
    logic [EDGE_ADDR_BITS-1:0] edge_idx_reg;
    logic [VERTEX_BITS-1:0]    vert_idx_reg;
    logic [VERTEX_BITS-1:0]    pass_reg;

    logic                      result_valid_reg;
    logic [PORT_VTX_BITS-1:0]  vertex_reg;
    logic [DIST_BITS-1:0]      distance_reg;
    logic                      reachable_reg;
    logic                      negative_cycle_reg;
    logic                      last_reg;

    logic [VCOUNT_BITS-1:0]    n_sat;
    logic                      edge_wr;
    logic [EDGE_BITS-1:0]      edge_wr_data;
    logic [EDGE_BITS-1:0]      edge_rd_data;
    logic [VERTEX_BITS-1:0]    e_from;
    logic [VERTEX_BITS-1:0]    e_to;
    logic [WEIGHT_BITS-1:0]    e_wt;
    logic [DIST_BITS-1:0]      e_wt_ext;

    logic                      dist_wr;
    logic [VERTEX_BITS-1:0]    dist_wr_addr;
    logic [DENTRY_BITS-1:0]    dist_wr_data;
    logic [VERTEX_BITS-1:0]    dist_a_addr;
    logic [DENTRY_BITS-1:0]    dist_a_data;
    logic [DENTRY_BITS-1:0]    dist_b_data;
    logic signed [DIST_BITS-1:0] cand;
    logic signed [DIST_BITS-1:0] dist_to;

    // Out-of-range vertex counts are pulled back into one to the maximum.
    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            n_sat = VCOUNT_BITS'(1);
        end
        else if (vertex_count_reg > VCOUNT_BITS'(MAX_VERTICES))
        begin
            n_sat = VCOUNT_BITS'(MAX_VERTICES);
        end
        else
        begin
            n_sat = vertex_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VCOUNT_BITS'(1);
            source_reg       <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_VERTEX_COUNT:  vertex_count_reg <= cfg_data[VCOUNT_BITS-1:0];
                CFG_SOURCE_VERTEX: source_reg       <= cfg_data[VERTEX_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Edge store: appends beyond the capacity are dropped.
    assign edge_wr      = cmd.append_edge && (edge_total_reg < EDGE_CNT_BITS'(MAX_EDGES));
    assign edge_wr_data = {from_vertex[VERTEX_BITS-1:0], to_vertex[VERTEX_BITS-1:0],
                           weight[WEIGHT_BITS-1:0]};

    bfsp_ram #(
        .WIDTH (EDGE_BITS),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (edge_wr),
        .wr_addr (edge_total_reg[EDGE_ADDR_BITS-1:0]),
        .wr_data (edge_wr_data),
        .rd_en   (cmd.edge_rd),
        .rd_addr (edge_idx_reg),
        .rd_data (edge_rd_data)
    );

    assign e_from   = edge_rd_data[EDGE_BITS-1 -: VERTEX_BITS];
    assign e_to     = edge_rd_data[WEIGHT_BITS +: VERTEX_BITS];
    assign e_wt     = edge_rd_data[WEIGHT_BITS-1:0];
    assign e_wt_ext = {{(DIST_BITS-WEIGHT_BITS){e_wt[WEIGHT_BITS-1]}}, e_wt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_total_reg <= '0;
            edge_idx_reg   <= '0;
            vert_idx_reg   <= '0;
            pass_reg       <= '0;
        end
        else
        begin
            if (cmd.clear_edges)
            begin
                edge_total_reg <= '0;
            end
            else if (edge_wr)
            begin
                edge_total_reg <= edge_total_reg + EDGE_CNT_BITS'(1);
            end

            if (cmd.edge_clr)
            begin
                edge_idx_reg <= '0;
            end
            else if (cmd.edge_inc)
            begin
                edge_idx_reg <= edge_idx_reg + EDGE_ADDR_BITS'(1);
            end

            if (cmd.vert_clr)
            begin
                vert_idx_reg <= '0;
            end
            else if (cmd.vert_inc)
            begin
                vert_idx_reg <= vert_idx_reg + VERTEX_BITS'(1);
            end

            if (cmd.pass_clr)
            begin
                pass_reg <= '0;
            end
            else if (cmd.pass_inc)
            begin
                pass_reg <= pass_reg + VERTEX_BITS'(1);
            end
        end
    end

    // Two copies of the distance store, written together, so that the tail and
    // head of an edge are read in the same cycle.
    assign dist_a_addr = cmd.out_rd ? vert_idx_reg : e_from;

    // Distances never leave 32 bits: the worst descent over all passes is
    // bounded by passes times edges times the largest weight.
    assign dist_to = dist_b_data[DIST_BITS-1:0];
    assign cand    = dist_a_data[DIST_BITS-1:0] + e_wt_ext;

    assign status.improve = (VCOUNT_BITS'(e_from) < n_sat)
                         && (VCOUNT_BITS'(e_to) < n_sat)
                         && dist_a_data[DIST_BITS]
                         && (!dist_b_data[DIST_BITS] || (cand < dist_to));

    always_comb
    begin
        dist_wr      = 1'b0;
        dist_wr_addr = vert_idx_reg;
        dist_wr_data = '0;
        if (cmd.init_wr)
        begin
            dist_wr      = 1'b1;
            dist_wr_data = {(vert_idx_reg == source_reg), {DIST_BITS{1'b0}}};
        end
        else if (cmd.relax_wr && status.improve)
        begin
            dist_wr      = 1'b1;
            dist_wr_addr = e_to;
            dist_wr_data = {1'b1, cand};
        end
    end

    bfsp_ram #(
        .WIDTH (DENTRY_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram_a (
        .clk     (clk),
        .wr_en   (dist_wr),
        .wr_addr (dist_wr_addr),
        .wr_data (dist_wr_data),
        .rd_en   (cmd.dist_rd || cmd.out_rd),
        .rd_addr (dist_a_addr),
        .rd_data (dist_a_data)
    );

    bfsp_ram #(
        .WIDTH (DENTRY_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram_b (
        .clk     (clk),
        .wr_en   (dist_wr),
        .wr_addr (dist_wr_addr),
        .wr_data (dist_wr_data),
        .rd_en   (cmd.dist_rd),
        .rd_addr (e_to),
        .rd_data (dist_b_data)
    );

    assign status.vert_last   = ((VCOUNT_BITS'(vert_idx_reg) + VCOUNT_BITS'(1)) == n_sat);
    assign status.detect_pass = ((VCOUNT_BITS'(pass_reg) + VCOUNT_BITS'(1)) == n_sat);
    assign status.edge_last   = ((EDGE_CNT_BITS'(edge_idx_reg) + EDGE_CNT_BITS'(1))
                                 == edge_total_reg);
    assign status.edge_empty  = (edge_total_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit || cmd.emit_neg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_neg)
        begin
            vertex_reg         <= '0;
            distance_reg       <= '0;
            reachable_reg      <= 1'b0;
            negative_cycle_reg <= 1'b1;
            last_reg           <= 1'b1;
        end
        else if (cmd.emit)
        begin
            vertex_reg         <= PORT_VTX_BITS'(vert_idx_reg);
            distance_reg       <= dist_a_data[DIST_BITS] ? dist_a_data[DIST_BITS-1:0] : '0;
            reachable_reg      <= dist_a_data[DIST_BITS];
            negative_cycle_reg <= 1'b0;
            last_reg           <= status.vert_last;
        end
    end

    assign result_valid   = result_valid_reg;
    assign vertex         = vertex_reg;
    assign distance       = distance_reg;
    assign reachable      = reachable_reg;
    assign negative_cycle = negative_cycle_reg;
    assign last           = last_reg;

endmodule
